[design/rwam_pkg.sv]
// Shared types, constants and the arctangent table of the radial wipe alpha mask.
`default_nettype none
package rwam_pkg;

  localparam int COORD_BITS    = 12;
  localparam int CORDIC_STAGES = 16;

  localparam int ATAN_LEN   = 20;
  localparam int ATAN_IDX_W = 5;
  localparam int CORDIC_RUN = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  localparam int CENTER_W = 16;
  localparam int ANGLE_W  = 16;
  localparam int WIPE_W   = 17;
  localparam int GAIN_W   = 24;
  localparam int EDGE_W   = 17;
  localparam int PROD_W   = EDGE_W + GAIN_W;
  localparam int ALPHA_W  = 9;
  localparam int CHAN_W   = 8;

  // Pixel offset from the centre carries 4 fraction bits plus a sign.
  localparam int D_W  = ((COORD_BITS + 4 > CENTER_W) ? COORD_BITS + 4 : CENTER_W) + 1;
  // Two bits of headroom cover the vector length times the CORDIC gain.
  localparam int XY_W = D_W + 2;

  localparam logic [ANGLE_W-1:0] HALF_TURN      = ANGLE_W'(32768);
  localparam logic [GAIN_W-1:0]  FEATHER_RESET  = GAIN_W'(30175);
  localparam int                 ALPHA_ONE      = 256;

  // Register indexes on the configuration port
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_ANGLE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WIPE_ANGLE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FEATHER_GAIN = 3'd4;
  localparam int PADDR_W = REG_IDX_W + 2;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [CHAN_W-1:0]     in_red;
    logic [CHAN_W-1:0]     in_green;
    logic [CHAN_W-1:0]     in_blue;
    logic [CHAN_W-1:0]     in_opacity;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_opacity;
    logic              was_scaled;
  } out_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] opacity;
  } chan_t;

  // Working set handed from cell to cell
  typedef struct packed {
    logic                   at_center;
    chan_t                  chan;
    logic [ANGLE_W-1:0]     z;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } cord_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
  } center_cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] origin_angle;
    logic [WIPE_W-1:0]  wipe_angle;
    logic [GAIN_W-1:0]  feather_gain;
  } wipe_cfg_t;

  // round(atan(2^-i) / (2*pi) * 65536)
  function automatic logic [ANGLE_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] val;
    unique case (idx)
      5'd0:    val = 16'd8192;
      5'd1:    val = 16'd4836;
      5'd2:    val = 16'd2555;
      5'd3:    val = 16'd1297;
      5'd4:    val = 16'd651;
      5'd5:    val = 16'd326;
      5'd6:    val = 16'd163;
      5'd7:    val = 16'd81;
      5'd8:    val = 16'd41;
      5'd9:    val = 16'd20;
      5'd10:   val = 16'd10;
      5'd11:   val = 16'd5;
      5'd12:   val = 16'd3;
      5'd13:   val = 16'd1;
      5'd14:   val = 16'd1;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

[design/rwam_front.sv]
// Entry cell: offset from the wipe centre and fold into the right half plane.
`default_nettype none
module rwam_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      up_valid,
  input  rwam_pkg::in_item_t       up_item,
  output logic                     up_ready,
  input  rwam_pkg::center_cfg_t    center,
  output logic                     dn_valid,
  output rwam_pkg::cord_t          dn_data,
  input  wire                      dn_ready
);
  import rwam_pkg::*;

  logic                  vld_r;
  cord_t                 data_r;
  cord_t                 data_nxt;
  logic [D_W-1:0]        px_ext;
  logic [D_W-1:0]        cx_ext;
  logic [D_W-1:0]        py_ext;
  logic [D_W-1:0]        cy_ext;
  logic signed [D_W-1:0] dx;
  logic signed [D_W-1:0] dy;

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  always_comb begin
    px_ext = D_W'({up_item.pixel_x, 4'b0000});
    py_ext = D_W'({up_item.pixel_y, 4'b0000});
    cx_ext = D_W'(center.center_x);
    cy_ext = D_W'(center.center_y);
    dx     = $signed(px_ext - cx_ext);
    dy     = $signed(py_ext - cy_ext);

    data_nxt.at_center    = (dx == '0) && (dy == '0);
    data_nxt.chan.red     = up_item.in_red;
    data_nxt.chan.green   = up_item.in_green;
    data_nxt.chan.blue    = up_item.in_blue;
    data_nxt.chan.opacity = up_item.in_opacity;
    // Left half plane: rotate by half a turn first
    if (dx[D_W-1]) begin
      data_nxt.x = -XY_W'(dx);
      data_nxt.y = -XY_W'(dy);
      data_nxt.z = HALF_TURN;
    end else begin
      data_nxt.x = XY_W'(dx);
      data_nxt.y = XY_W'(dy);
      data_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

[design/rwam_cell.sv]
// One CORDIC vectoring micro-rotation with its own pipeline register.
`default_nettype none
module rwam_cell (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire [rwam_pkg::ATAN_IDX_W-1:0]       shift,
  input  wire                                  up_valid,
  input  rwam_pkg::cord_t                      up_data,
  output logic                                 up_ready,
  output logic                                 dn_valid,
  output rwam_pkg::cord_t                      dn_data,
  input  wire                                  dn_ready
);
  import rwam_pkg::*;

  logic                   vld_r;
  cord_t                  data_r;
  cord_t                  data_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  always_comb begin
    xs       = up_data.x >>> shift;
    ys       = up_data.y >>> shift;
    data_nxt = up_data;
    // Rotate towards the x axis
    if (!up_data.y[XY_W-1]) begin
      data_nxt.x = up_data.x + ys;
      data_nxt.y = up_data.y - xs;
      data_nxt.z = up_data.z + atan_turn(shift);
    end else begin
      data_nxt.x = up_data.x - ys;
      data_nxt.y = up_data.y + xs;
      data_nxt.z = up_data.z - atan_turn(shift);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

[design/rwam_back.sv]
// Exit stages: wipe edge distance times feather gain, then alpha scaling of the pixel.
`default_nettype none
module rwam_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    up_valid,
  input  rwam_pkg::cord_t        up_data,
  output logic                   up_ready,
  input  rwam_pkg::wipe_cfg_t    wipe,
  output logic                   dn_valid,
  output rwam_pkg::out_item_t    dn_item,
  input  wire                    dn_ready
);
  import rwam_pkg::*;

  // Stage A: product of edge distance and gain
  logic                 a_vld_r;
  logic [PROD_W-1:0]    a_prod_r;
  logic [PROD_W-1:0]    a_prod_nxt;
  chan_t                a_chan_r;
  logic                 a_ready;
  logic [ANGLE_W-1:0]   z_eff;
  logic [ANGLE_W-1:0]   ang;
  logic [WIPE_W:0]      edge_s;
  logic [EDGE_W-1:0]    edge_dist;

  // Stage B: output register
  logic                  b_vld_r;
  out_item_t             b_item_r;
  out_item_t             b_item_nxt;
  logic [PROD_W-17:0]    alpha_full;
  logic                  sat;
  logic [ALPHA_W-1:0]    alpha;
  logic [CHAN_W+ALPHA_W-1:0] m_red;
  logic [CHAN_W+ALPHA_W-1:0] m_green;
  logic [CHAN_W+ALPHA_W-1:0] m_blue;
  logic [CHAN_W+ALPHA_W-1:0] m_opacity;

  assign a_ready  = !b_vld_r || dn_ready;
  assign up_ready = !a_vld_r || a_ready;
  assign dn_valid = b_vld_r;
  assign dn_item  = b_item_r;

  always_comb begin
    z_eff  = up_data.at_center ? '0 : up_data.z;
    ang    = z_eff - wipe.origin_angle;
    edge_s = {1'b0, wipe.wipe_angle} - (WIPE_W + 1)'(ang);
    // Past the wipe edge: wrap forward by one turn
    if (edge_s[WIPE_W]) begin
      edge_dist = edge_s[EDGE_W-1:0] + EDGE_W'(65536);
    end else begin
      edge_dist = edge_s[EDGE_W-1:0];
    end
    a_prod_nxt = PROD_W'(edge_dist) * PROD_W'(wipe.feather_gain);
  end

  always_comb begin
    alpha_full = a_prod_r[PROD_W-1:16];
    sat        = (alpha_full >= (PROD_W - 16)'(ALPHA_ONE));
    alpha      = alpha_full[ALPHA_W-1:0];
    m_red      = (CHAN_W + ALPHA_W)'(a_chan_r.red) * (CHAN_W + ALPHA_W)'(alpha);
    m_green    = (CHAN_W + ALPHA_W)'(a_chan_r.green) * (CHAN_W + ALPHA_W)'(alpha);
    m_blue     = (CHAN_W + ALPHA_W)'(a_chan_r.blue) * (CHAN_W + ALPHA_W)'(alpha);
    m_opacity  = (CHAN_W + ALPHA_W)'(a_chan_r.opacity) * (CHAN_W + ALPHA_W)'(alpha);
    if (sat) begin
      b_item_nxt.out_red     = a_chan_r.red;
      b_item_nxt.out_green   = a_chan_r.green;
      b_item_nxt.out_blue    = a_chan_r.blue;
      b_item_nxt.out_opacity = a_chan_r.opacity;
      b_item_nxt.was_scaled  = 1'b0;
    end else begin
      b_item_nxt.out_red     = m_red[CHAN_W+7:8];
      b_item_nxt.out_green   = m_green[CHAN_W+7:8];
      b_item_nxt.out_blue    = m_blue[CHAN_W+7:8];
      b_item_nxt.out_opacity = m_opacity[CHAN_W+7:8];
      b_item_nxt.was_scaled  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (up_ready) begin
        a_vld_r <= up_valid;
      end
      if (a_ready) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      a_prod_r <= a_prod_nxt;
      a_chan_r <= up_data.chan;
    end
    if (a_ready) begin
      b_item_r <= b_item_nxt;
    end
  end

endmodule
`default_nettype wire

[design/radial_wipe_alpha_mask.sv]
// Top level of the radial (clock) wipe alpha mask.
//
//  port group      direction  handshake               payload
//  in_*            in         in_valid / in_ready     in_item  (pixel x, y, RGBA)
//  out_*           out        out_valid / out_ready   out_item (scaled RGBA, was_scaled)
//  APB             in/out     psel, penable, pready   paddr, pwdata, prdata
//
// One pixel request is taken every clock while in_ready is high; the path runs through
// the entry cell, 16 CORDIC cells, edge-times-gain stage and output register.
// Throughput is set by the cell chain, each cell doing one micro-rotation per cycle.
// Every stage has its own valid bit and stalls only when the stage after it is
// full and held, so bubbles collapse and in_ready stays high while out_ready is
// low until the chain fills. Reset is synchronous: it empties the chain and
// reloads the registers.
`default_nettype none
module radial_wipe_alpha_mask (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  rwam_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  wire                            out_ready,
  output rwam_pkg::out_item_t            out_item,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [rwam_pkg::PADDR_W-1:0]    paddr,
  input  wire [31:0]                     pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rwam_pkg::*;

  logic [CENTER_W-1:0] center_x_r;
  logic [CENTER_W-1:0] center_y_r;
  logic [ANGLE_W-1:0]  origin_angle_r;
  logic [WIPE_W-1:0]   wipe_angle_r;
  logic [GAIN_W-1:0]   feather_gain_r;
  logic                cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  center_cfg_t center;
  wipe_cfg_t   wipe;

  // Cell chain: link k feeds cell k, link 0 comes from the entry cell
  cord_t chain_data  [0:CORDIC_RUN];
  logic  chain_valid [0:CORDIC_RUN];
  logic  chain_ready [0:CORDIC_RUN];

  // --- configuration port -------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      origin_angle_r <= '0;
      wipe_angle_r   <= '0;
      feather_gain_r <= FEATHER_RESET;
    end else if (cfg_wr) begin
      // Writes to unused indexes drop silently
      unique case (cfg_idx)
        REG_CENTER_X:     center_x_r     <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y:     center_y_r     <= pwdata[CENTER_W-1:0];
        REG_ORIGIN_ANGLE: origin_angle_r <= pwdata[ANGLE_W-1:0];
        REG_WIPE_ANGLE:   wipe_angle_r   <= pwdata[WIPE_W-1:0];
        REG_FEATHER_GAIN: feather_gain_r <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER_X:     prdata = 32'(center_x_r);
      REG_CENTER_Y:     prdata = 32'(center_y_r);
      REG_ORIGIN_ANGLE: prdata = 32'(origin_angle_r);
      REG_WIPE_ANGLE:   prdata = 32'(wipe_angle_r);
      REG_FEATHER_GAIN: prdata = 32'(feather_gain_r);
      default:          prdata = '0;
    endcase
  end

  assign center = '{center_x: center_x_r, center_y: center_y_r};
  assign wipe   = '{origin_angle: origin_angle_r, wipe_angle: wipe_angle_r,
                    feather_gain: feather_gain_r};

  // --- datapath -----------------------------------------------------------
  // Entry cell: offset from the centre, fold left half plane by half a turn
  rwam_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_item  (in_item),
    .up_ready (in_ready),
    .center   (center),
    .dn_valid (chain_valid[0]),
    .dn_data  (chain_data[0]),
    .dn_ready (chain_ready[0])
  );

  // CORDIC cells, cell k shifts by k and adds or drops atan(2^-k)
  for (genvar k = 0; k < CORDIC_RUN; k++) begin : g_cell
    rwam_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (ATAN_IDX_W'(k)),
      .up_valid (chain_valid[k]),
      .up_data  (chain_data[k]),
      .up_ready (chain_ready[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_data  (chain_data[k+1]),
      .dn_ready (chain_ready[k+1])
    );
  end

  // Angle to alpha, then scale the pixel into the output register
  rwam_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chain_valid[CORDIC_RUN]),
    .up_data  (chain_data[CORDIC_RUN]),
    .up_ready (chain_ready[CORDIC_RUN]),
    .wipe     (wipe),
    .dn_valid (out_valid),
    .dn_item  (out_item),
    .dn_ready (out_ready)
  );

endmodule
`default_nettype wire

[design/rwam_checker.sv]
// Port-level checks of the radial wipe alpha mask, bound to the top level.
`default_nettype none
module rwam_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_ready,
  input rwam_pkg::in_item_t             in_item,
  input wire                            out_valid,
  input wire                            out_ready,
  input rwam_pkg::out_item_t            out_item,
  input wire                            psel,
  input wire                            penable,
  input wire                            pwrite,
  input wire [rwam_pkg::PADDR_W-1:0]    paddr,
  input wire [31:0]                     pwdata,
  input wire [31:0]                     prdata,
  input wire                            pready
);
  import rwam_pkg::*;

  // Held request keeps its value
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("request changed while stalled");

  // Held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Reset empties the chain
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  // Input backpressure only when the output is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free output");

  // A written start angle reads back at the same address
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_ORIGIN_ANGLE)
    ##1 (paddr == $past(paddr))
    |-> prdata == 32'($past(pwdata[ANGLE_W-1:0])))
    else $error("start angle read-back mismatch");

endmodule

bind radial_wipe_alpha_mask rwam_checker u_rwam_checker (.*);
`default_nettype wire
